/* hw/rtl/s2i_pkg.sv */
package s2i_pkg;

    // Longest string the count tracks; the count saturates below 256
    localparam int unsigned MAX_STRING_LENGTH = 255;
    localparam int unsigned COUNT_LIMIT_I =
        (MAX_STRING_LENGTH < 255) ? MAX_STRING_LENGTH : 255;
    localparam logic [7:0] COUNT_LIMIT = COUNT_LIMIT_I[7:0];

    // Register indexes of the configuration port
    localparam logic CFG_BASE_SELECT = 1'b0;
    localparam logic CFG_SIGNED_MODE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [4:0] BASE_RESET   = 5'd10;
    localparam logic       SIGNED_RESET = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    // Bases
    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    // Digit value that no base accepts
    localparam logic [4:0] NOT_DIGIT = 5'd31;

    typedef logic [4:0] t_digit;

    // Value of a hex digit character, NOT_DIGIT for anything else
    function automatic t_digit digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = c - CH_ZERO;
        end else if (c inside {[CH_LC_A:CH_LC_F]}) begin
            d = c - CH_LC_A + 8'd10;
        end else if (c inside {[CH_UC_A:CH_UC_F]}) begin
            d = c - CH_UC_A + 8'd10;
        end else begin
            d = {3'b000, NOT_DIGIT};
        end
        return d[4:0];
    endfunction

    function automatic logic is_x(input logic [7:0] c);
        return (c == CH_LC_X) || (c == CH_UC_X);
    endfunction

endpackage

/* hw/rtl/string_to_integer_parser_core.sv */
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------------
// in       | i_in_valid / o_in_ready    | i_char_code, i_end_of_string
// out      | o_out_valid / i_out_ready  | o_parsed_value, o_consumed_count,
//          |                            | o_was_negative
// cfg      | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One character per cycle sustained while the parse stage is not held. A
// character is taken into an input register, then decoded and folded into
// the accumulator (one 32x5 multiply and add) from there, and any result is
// then registered in the output register. A waiting result does not block intake: the
// parse stage only holds while it must emit and the output register is full.
// Reset (i_rst_n low at a clock edge) clears all control and string state.
module string_to_integer_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_string,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_parsed_value,
    output logic [7:0]  o_consumed_count,
    output logic        o_was_negative,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_PREFIX    = 3'd1;
    localparam logic [2:0] PH_ZERO_AUTO = 3'd2;
    localparam logic [2:0] PH_X_PENDING = 3'd3;
    localparam logic [2:0] PH_ZERO_HEX  = 3'd4;
    localparam logic [2:0] PH_DIGITS    = 3'd5;

    // Configuration
    logic [4:0]  r_base_select;
    logic        r_signed_mode;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_eos;

    // String state
    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [4:0]  r_eb, n_eb;
    logic [7:0]  r_count, n_count;
    logic        r_minus, n_minus;
    logic        r_sent, n_sent;

    // Output register
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic [7:0]  r_out_count;
    logic        r_out_neg;

    logic        w_fire;
    logic        w_emit;
    logic        w_parse_emit;
    logic        w_do_feed;
    logic        w_prefix;
    logic [4:0]  w_fb;
    logic [1:0]  w_inc;
    logic [4:0]  w_dig;
    logic [4:0]  w_bsel;
    logic [36:0] w_prod;
    logic [31:0] w_acc_fed;
    logic [8:0]  w_count_sum;
    logic [31:0] w_value;

    // Parse stage moves unless it must emit into a full output register
    assign w_fire     = r_in_valid && (!w_emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    assign w_dig     = s2i_pkg::digit_of(r_in_char);
    assign w_bsel    = (r_base_select > s2i_pkg::BASE_HEX) ? s2i_pkg::BASE_HEX
                                                           : r_base_select;
    assign w_prod    = r_acc * w_fb;
    assign w_acc_fed = w_prod[31:0] + {27'd0, w_dig};

    // Decode one character against the string state
    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_eb         = r_eb;
        n_minus      = r_minus;
        n_sent       = r_sent;
        w_fb         = r_eb;
        w_inc        = 2'd0;
        w_do_feed    = 1'b0;
        w_prefix     = 1'b0;
        w_parse_emit = 1'b0;

        if (!r_sent) begin
            case (r_phase)
                PH_START: begin
                    if (r_signed_mode && (r_in_char == s2i_pkg::CH_MINUS)) begin
                        n_minus = 1'b1;
                        w_inc   = 2'd1;
                        n_phase = PH_PREFIX;
                    end else begin
                        w_prefix = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    w_prefix = 1'b1;
                end
                PH_ZERO_AUTO: begin
                    if (s2i_pkg::is_x(r_in_char)) begin
                        n_phase = PH_X_PENDING;
                    end else begin
                        w_do_feed = 1'b1;
                    end
                end
                PH_X_PENDING: begin
                    if (w_dig < s2i_pkg::BASE_HEX) begin
                        n_eb      = s2i_pkg::BASE_HEX;
                        w_fb      = s2i_pkg::BASE_HEX;
                        w_inc     = 2'd1;
                        w_do_feed = 1'b1;
                    end else begin
                        w_parse_emit = 1'b1;
                    end
                end
                PH_ZERO_HEX: begin
                    if (s2i_pkg::is_x(r_in_char)) begin
                        w_inc   = 2'd1;
                        n_phase = PH_DIGITS;
                    end else begin
                        w_do_feed = 1'b1;
                    end
                end
                default: begin
                    w_do_feed = 1'b1;
                end
            endcase

            // Latch the base from the register, or take an auto prefix zero
            if (w_prefix) begin
                if (r_base_select == 5'd0) begin
                    if (r_in_char == s2i_pkg::CH_ZERO) begin
                        n_eb    = s2i_pkg::BASE_OCT;
                        w_inc   = 2'd1;
                        n_phase = PH_ZERO_AUTO;
                    end else begin
                        n_eb      = s2i_pkg::BASE_DEC;
                        w_fb      = s2i_pkg::BASE_DEC;
                        w_do_feed = 1'b1;
                    end
                end else begin
                    n_eb = w_bsel;
                    w_fb = w_bsel;
                    if ((w_bsel == s2i_pkg::BASE_HEX) &&
                        (r_in_char == s2i_pkg::CH_ZERO)) begin
                        w_inc   = 2'd1;
                        n_phase = PH_ZERO_HEX;
                    end else begin
                        w_do_feed = 1'b1;
                    end
                end
            end

            // Fold a digit in, or stop at a non-digit
            if (w_do_feed) begin
                if (w_dig < w_fb) begin
                    n_acc   = w_acc_fed;
                    w_inc   = w_inc + 2'd1;
                    n_phase = PH_DIGITS;
                end else begin
                    w_parse_emit = 1'b1;
                end
            end
        end

        w_emit = w_parse_emit || (!r_sent && r_in_eos);
        if (w_emit) begin
            n_sent = 1'b1;
        end
    end

    // Saturating character count
    assign w_count_sum = {1'b0, r_count} + {7'd0, w_inc};
    assign n_count = (w_count_sum > {1'b0, s2i_pkg::COUNT_LIMIT}) ? s2i_pkg::COUNT_LIMIT
                                                                  : w_count_sum[7:0];

    assign w_value = n_minus ? (32'd0 - n_acc) : n_acc;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_select <= s2i_pkg::BASE_RESET;
            r_signed_mode <= s2i_pkg::SIGNED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                s2i_pkg::CFG_BASE_SELECT: r_base_select <= i_cfg_data;
                s2i_pkg::CFG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_char_code;
            r_in_eos  <= i_end_of_string;
        end
    end

    // Advance string state; clear it after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= 32'd0;
            r_eb    <= s2i_pkg::BASE_DEC;
            r_count <= 8'd0;
            r_minus <= 1'b0;
            r_sent  <= 1'b0;
        end else if (w_fire) begin
            if (r_in_eos) begin
                r_phase <= PH_START;
                r_acc   <= 32'd0;
                r_eb    <= s2i_pkg::BASE_DEC;
                r_count <= 8'd0;
                r_minus <= 1'b0;
                r_sent  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_eb    <= n_eb;
                r_count <= n_count;
                r_minus <= n_minus;
                r_sent  <= n_sent;
            end
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_value <= w_value;
            r_out_count <= n_count;
            r_out_neg   <= n_minus;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_parsed_value   = r_out_value;
    assign o_consumed_count = r_out_count;
    assign o_was_negative   = r_out_neg;

    // The last character of a string leaves a clean start
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_eos) |=>
            (r_phase == PH_START) && !r_sent && (r_count == 8'd0) && !r_minus)
        else $error("string state not cleared after last character");

    // Count never passes its saturation limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= s2i_pkg::COUNT_LIMIT)
        else $error("character count above limit");

    // A taken minus always moves the phase on
    a_minus_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_minus |-> (r_phase != PH_START))
        else $error("minus taken but phase still at start");

    // Latched base stays within 1 to 16
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eb != 5'd0) && (r_eb <= s2i_pkg::BASE_HEX))
        else $error("effective base out of range");

    // A stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(w_fire && w_emit))
        else $error("parse stage emitted into a full output register");

endmodule
